@@ rtl/opp_pkg.sv @@
// shared widths, types, register indexes and arithmetic helpers for the overlap pair block
`default_nettype none
package opp_pkg;

   localparam int RAD_W     = 19;
   localparam int DIST_W    = 20;
   localparam int WGT_W     = 32;
   localparam int OUT_W     = 32;
   localparam int CFG_W     = 31;
   localparam int EXP_W     = 7;
   localparam int CSR_IDX_W = 2;

   // signed working values, Q16 or Q24 depending on the step
   localparam int VAL_W   = 64;
   // multiplier operand magnitudes, consumed one chunk per cycle
   localparam int MAG_W   = 48;
   localparam int CHUNK_W = 16;
   localparam int CHUNKS  = MAG_W / CHUNK_W;
   localparam int PROD_W  = 2 * MAG_W;
   // divider numerator and denominator magnitudes
   localparam int NUM_W   = 52;
   localparam int DEN_W   = 31;
   localparam int QUO_W   = NUM_W + 1;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [MAG_W-1:0]        mag_type;
   typedef logic [PROD_W-1:0]       prod_type;
   typedef logic [NUM_W-1:0]        num_type;
   typedef logic [DEN_W-1:0]        den_type;
   typedef logic [QUO_W-1:0]        quo_type;

   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORE_COEF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORE_EXP  = 2'd2;

   localparam val_type LIM     = val_type'(64'sd1 <<< 40);
   localparam val_type ONE_Q16 = val_type'(64'sd65536);

   function automatic logic [VAL_W-1:0] mag_of(input val_type v);
      val_type n;
      n = -v;
      return (v < 0) ? $unsigned(n) : $unsigned(v);
   endfunction

   function automatic val_type apply_sign(input logic neg, input logic [VAL_W-1:0] m);
      val_type s;
      s = $signed(m);
      return neg ? -s : s;
   endfunction

   function automatic logic over_lim(input val_type v);
      return (v > LIM) || (v < -LIM);
   endfunction

   function automatic val_type clampw(input val_type v);
      val_type r;
      r = v;
      if (v > LIM) r = LIM;
      else if (v < -LIM) r = -LIM;
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/opp_req_if.sv @@
// input channel: two radii, distance, energy weight and core flag
`default_nettype none
interface opp_req_if import opp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [RAD_W-1:0]        radius_a;
   logic [RAD_W-1:0]        radius_b;
   logic [DIST_W-1:0]       distance;
   logic signed [WGT_W-1:0] energy_weight;
   logic                    include_core;

   modport source (output valid, radius_a, radius_b, distance, energy_weight, include_core,
                   input ready);
   modport sink   (input valid, radius_a, radius_b, distance, energy_weight, include_core,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/opp_rsp_if.sv @@
// result channel: potential, force and saturation flag
`default_nettype none
interface opp_rsp_if import opp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] potential;
   logic signed [OUT_W-1:0] force_res;
   logic                    saturated;

   modport source (output valid, potential, force_res, saturated, input ready);
   modport sink   (input valid, potential, force_res, saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/opp_csr_if.sv @@
// register write channel: index and data
`default_nettype none
interface opp_csr_if import opp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/opp_mul.sv @@
// shared magnitude multiplier, one 16-bit chunk of the second operand per cycle
`default_nettype none
module opp_mul import opp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  mag_type  op_a,
   input  mag_type  op_b,
   output logic     done,
   output prod_type prod
);

   localparam int CNT_W = $clog2(CHUNKS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHUNKS - 1);

   mag_type                    a_ff, a_in;
   mag_type                    b_ff, b_in;
   prod_type                   acc_ff, acc_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [MAG_W+CHUNK_W-1:0]   part;

   always_comb begin
      part    = a_ff * b_ff[MAG_W-1 -: CHUNK_W];
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // high chunk first, so the running sum only ever shifts left
         acc_in = (acc_ff << CHUNK_W) + prod_type'(part);
         b_in   = b_ff << CHUNK_W;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

@@ rtl/opp_div.sv @@
// restoring divider, one quotient bit per cycle, rounds to nearest
`default_nettype none
module opp_div import opp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  num_type num,
   input  den_type den,
   output logic    done,
   output quo_type quo
);

   localparam int CNT_W = $clog2(QUO_W);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(QUO_W - 1);

   quo_type            work_ff, work_in;
   den_type            den_ff, den_in;
   den_type            rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DEN_W:0]     trial;
   logic [DEN_W:0]     diff;
   logic               take;

   always_comb begin
      trial   = {rem_ff, work_ff[QUO_W-1]};
      diff    = trial - {1'b0, den_ff};
      take    = trial >= {1'b0, den_ff};
      work_in = work_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // half the divisor added up front gives round to nearest
         work_in = quo_type'(num) + quo_type'(den >> 1);
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CNT_TOP;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         work_in = {work_ff[QUO_W-2:0], take};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = work_ff;

endmodule
`default_nettype wire

@@ rtl/overlap_pair_potential_force.sv @@
// sphere overlap pair potential and force: sequencer and datapath around shared mul and div
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    radius_a, radius_b, distance, energy_weight, include_core
//   rsp_if   out  valid/ready    potential, force_res, saturated
//   csr_if   in   valid/ready    index, data (cutoff, core_coefficient, core_exponent)
//
// one item at a time; each multiply steps through the second operand chunk by chunk, each divide bit by bit.
// separated spheres, nested spheres and overlapping lenses run through different state paths.
// the soft core adds a power loop whose length follows core exponent n.
// synchronous active-high reset; registers come back as cutoff max, coefficient 0, exponent 1.
// req ready only in idle; the result is held until rsp ready, csr ready is always high.
`default_nettype none
module overlap_pair_potential_force import opp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   opp_req_if.sink   req_if,
   opp_rsp_if.source rsp_if,
   opp_csr_if.sink   csr_if
);

   typedef enum logic [26:0] {
      ST_IDLE     = 27'h1 << 0,
      ST_CLASSIFY = 27'h1 << 1,
      ST_ENC_SQ   = 27'h1 << 2,
      ST_ENC_CUBE = 27'h1 << 3,
      ST_LENS_RA2 = 27'h1 << 4,
      ST_LENS_RB2 = 27'h1 << 5,
      ST_LENS_T   = 27'h1 << 6,
      ST_LENS_S1  = 27'h1 << 7,
      ST_LENS_X1  = 27'h1 << 8,
      ST_LENS_S2  = 27'h1 << 9,
      ST_LENS_X2  = 27'h1 << 10,
      ST_LENS_S3  = 27'h1 << 11,
      ST_LENS_Y1  = 27'h1 << 12,
      ST_LENS_S4  = 27'h1 << 13,
      ST_LENS_Y2  = 27'h1 << 14,
      ST_LENS_DV  = 27'h1 << 15,
      ST_W_U      = 27'h1 << 16,
      ST_W_F      = 27'h1 << 17,
      ST_CORE_POW = 27'h1 << 18,
      ST_CORE_RM  = 27'h1 << 19,
      ST_CORE_EE  = 27'h1 << 20,
      ST_CORE_U   = 27'h1 << 21,
      ST_CORE_CE  = 27'h1 << 22,
      ST_CORE_CER = 27'h1 << 23,
      ST_CORE_SC  = 27'h1 << 24,
      ST_FR       = 27'h1 << 25,
      ST_DONE     = 27'h1 << 26
   } state_type;

   state_type               state_ff, state_in;

   logic [CFG_W-1:0]        cutoff_ff, cutoff_in;
   logic [CFG_W-1:0]        coef_ff, coef_in;
   logic [EXP_W-1:0]        exp_ff, exp_in;

   logic [RAD_W-1:0]        ra_ff, ra_in;
   logic [RAD_W-1:0]        rb_ff, rb_in;
   logic [DIST_W-1:0]       r_ff, r_in;
   logic signed [WGT_W-1:0] w_ff, w_in;
   logic                    core_ff, core_in;

   val_type                 tp_ff, tp_in;
   val_type                 tm_ff, tm_in;
   val_type                 tmp_ff, tmp_in;
   val_type                 acc_ff, acc_in;
   val_type                 om_ff, om_in;
   val_type                 dv_ff, dv_in;
   val_type                 u_ff, u_in;
   val_type                 f_ff, f_in;
   val_type                 p_ff, p_in;
   val_type                 rm_ff, rm_in;
   logic [EXP_W-1:0]        cnt_ff, cnt_in;
   logic                    sat_ff, sat_in;
   logic                    issued_ff, issued_in;
   logic                    mul_neg_ff, mul_neg_in;
   logic                    div_neg_ff, div_neg_in;
   logic signed [OUT_W-1:0] pot_ff, pot_in;
   logic signed [OUT_W-1:0] frc_ff, frc_in;

   logic     req_acc;
   logic     mul_start, mul_done, div_start, div_done;
   logic     op_mul, op_div;
   val_type  opa, opb, div_num_v, div_den_v;
   logic [VAL_W-1:0] opa_mag, opb_mag, num_mag;
   prod_type prod;
   quo_type  quo;

   val_type  ra_v, rb_v, r_v, w_v, c_v, k_v, cut_v;
   val_type  a24, b24, h_v, m_v, sum_v, dif_v, rq_v, e_v;
   prod_type rnd24, rnd16, rnd30, rnd29;
   logic     sat16, raw_big, q_big;
   val_type  raw_v, v24, smul_v, sc_v, q_v;
   val_type  x_sum, y_sum, uc_v, fs_v, fr_v, pot_pre, nf_v;
   logic [VAL_W-1:0] om_mag;

   // operand and input views
   always_comb begin
      ra_v  = val_type'({1'b0, ra_ff});
      rb_v  = val_type'({1'b0, rb_ff});
      r_v   = val_type'({1'b0, r_ff});
      w_v   = val_type'(w_ff);
      c_v   = val_type'({1'b0, coef_ff});
      k_v   = val_type'({1'b0, exp_ff, 1'b0});
      cut_v = val_type'({1'b0, cutoff_ff});
      a24   = ra_v <<< 8;
      b24   = rb_v <<< 8;
      h_v   = r_v <<< 7;
      m_v   = (ra_v < rb_v) ? ra_v : rb_v;
      sum_v = ra_v + rb_v;
      dif_v = (ra_v > rb_v) ? (ra_v - rb_v) : (rb_v - ra_v);
      rq_v  = r_v <<< 14;
      e_v   = rm_ff - ONE_Q16;
   end

   // shared unit result views
   always_comb begin
      rnd24   = (prod + (prod_type'(1) << 23)) >> 24;
      rnd16   = (prod + (prod_type'(1) << 15)) >> 16;
      rnd30   = (prod + (prod_type'(1) << 29)) >> 30;
      rnd29   = (prod + (prod_type'(1) << 28)) >> 29;
      sat16   = prod > (prod_type'(1) << 56);
      raw_big = prod > prod_type'(LIM);
      raw_v   = apply_sign(mul_neg_ff, prod[VAL_W-1:0]);
      v24     = apply_sign(mul_neg_ff, rnd24[VAL_W-1:0]);
      smul_v  = sat16 ? (mul_neg_ff ? -LIM : LIM) : apply_sign(mul_neg_ff, rnd16[VAL_W-1:0]);
      sc_v    = raw_big ? (mul_neg_ff ? -LIM : LIM) : raw_v;
      q_big   = val_type'({1'b0, quo}) > LIM;
      q_v     = apply_sign(div_neg_ff, {{(VAL_W-QUO_W){1'b0}}, quo});
      x_sum   = acc_ff + v24;
      y_sum   = acc_ff - v24;
      om_mag  = ((mag_of(x_sum) << 1) + 64'd128) >> 8;
      uc_v    = u_ff + smul_v;
      fs_v    = f_ff - sc_v;
      fr_v    = raw_v;
      pot_pre = (u_ff > cut_v) ? cut_v : u_ff;
      nf_v    = -f_ff;
   end

   // shared unit operand selection
   always_comb begin
      opa       = '0;
      opb       = '0;
      div_num_v = '0;
      div_den_v = r_v;
      unique case (state_ff)
         ST_ENC_SQ:   begin opa = m_v;           opb = m_v;        end
         ST_ENC_CUBE: begin opa = tmp_ff;        opb = m_v;        end
         ST_LENS_RA2: begin opa = ra_v;          opb = ra_v;       end
         ST_LENS_RB2: begin opa = rb_v;          opb = rb_v;       end
         ST_LENS_T:   begin div_num_v = acc_ff <<< 7;                end
         ST_LENS_S1:  begin opa = a24 - tp_ff;   opb = a24 - tp_ff; end
         ST_LENS_X1:  begin opa = (a24 <<< 1) + tp_ff; opb = tmp_ff; end
         ST_LENS_S2:  begin opa = b24 + tm_ff;   opb = b24 + tm_ff; end
         ST_LENS_X2:  begin opa = (b24 <<< 1) - tm_ff; opb = tmp_ff; end
         ST_LENS_S3:  begin opa = a24 - tp_ff;   opb = a24 + tp_ff; end
         ST_LENS_Y1:  begin opa = tm_ff;         opb = tmp_ff;     end
         ST_LENS_S4:  begin opa = b24 - tm_ff;   opb = b24 + tm_ff; end
         ST_LENS_Y2:  begin opa = tp_ff;         opb = tmp_ff;     end
         // times 1536 as two shifts
         ST_LENS_DV:  begin div_num_v = (acc_ff <<< 10) + (acc_ff <<< 9); end
         ST_W_U:      begin opa = w_v;           opb = om_ff;      end
         ST_W_F:      begin opa = w_v;           opb = dv_ff;      end
         ST_CORE_POW: begin opa = p_ff;          opb = rq_v;       end
         ST_CORE_RM:  begin div_num_v = val_type'(64'sd1 <<< 46); div_den_v = p_ff; end
         ST_CORE_EE:  begin opa = e_v;           opb = e_v;        end
         ST_CORE_U:   begin opa = c_v;           opb = tmp_ff;     end
         ST_CORE_CE:  begin opa = c_v;           opb = e_v;        end
         ST_CORE_CER: begin opa = tmp_ff;        opb = rm_ff;      end
         ST_CORE_SC:  begin opa = tmp_ff;        opb = k_v;        end
         ST_FR:       begin opa = f_ff;          opb = r_v;        end
         default:     begin opa = '0;            opb = '0;         end
      endcase
      opa_mag = mag_of(opa);
      opb_mag = mag_of(opb);
      num_mag = mag_of(div_num_v);
   end

   assign req_acc = req_if.valid && req_if.ready;

   // sequencer and register updates
   always_comb begin
      state_in   = state_ff;
      cutoff_in  = cutoff_ff;
      coef_in    = coef_ff;
      exp_in     = exp_ff;
      ra_in      = ra_ff;
      rb_in      = rb_ff;
      r_in       = r_ff;
      w_in       = w_ff;
      core_in    = core_ff;
      tp_in      = tp_ff;
      tm_in      = tm_ff;
      tmp_in     = tmp_ff;
      acc_in     = acc_ff;
      om_in      = om_ff;
      dv_in      = dv_ff;
      u_in       = u_ff;
      f_in       = f_ff;
      p_in       = p_ff;
      rm_in      = rm_ff;
      cnt_in     = cnt_ff;
      sat_in     = sat_ff;
      issued_in  = issued_ff;
      mul_neg_in = mul_neg_ff;
      div_neg_in = div_neg_ff;
      pot_in     = pot_ff;
      frc_in     = frc_ff;

      if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            CSR_CUTOFF:    cutoff_in = csr_if.data;
            CSR_CORE_COEF: coef_in   = csr_if.data;
            CSR_CORE_EXP:  exp_in    = csr_if.data[EXP_W-1:0];
            default:       ;
         endcase
      end

      op_mul = (state_ff inside {ST_ENC_SQ, ST_ENC_CUBE, ST_LENS_RA2, ST_LENS_RB2,
                                 ST_LENS_S1, ST_LENS_X1, ST_LENS_S2, ST_LENS_X2,
                                 ST_LENS_S3, ST_LENS_Y1, ST_LENS_S4, ST_LENS_Y2,
                                 ST_W_U, ST_W_F, ST_CORE_EE, ST_CORE_U, ST_CORE_CE,
                                 ST_CORE_CER, ST_CORE_SC, ST_FR})
               || (state_ff == ST_CORE_POW && cnt_ff != exp_ff);
      op_div = state_ff inside {ST_LENS_T, ST_LENS_DV, ST_CORE_RM};

      mul_start = op_mul && !issued_ff;
      div_start = op_div && !issued_ff;
      if (mul_start) begin
         issued_in  = 1'b1;
         mul_neg_in = (opa < 0) != (opb < 0);
      end
      if (div_start) begin
         issued_in  = 1'b1;
         div_neg_in = div_num_v < 0;
      end
      if (mul_done || div_done) issued_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ra_in    = req_if.radius_a;
               rb_in    = req_if.radius_b;
               r_in     = req_if.distance;
               w_in     = req_if.energy_weight;
               core_in  = req_if.include_core;
               sat_in   = 1'b0;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (r_v > sum_v) begin
               om_in    = '0;
               dv_in    = '0;
               state_in = ST_W_U;
            end else if (r_v <= dif_v) begin
               state_in = ST_ENC_SQ;
            end else begin
               state_in = ST_LENS_RA2;
            end
         end
         ST_ENC_SQ: if (mul_done) begin
            tmp_in   = raw_v;
            state_in = ST_ENC_CUBE;
         end
         ST_ENC_CUBE: if (mul_done) begin
            // 8*m^3 taken from Q48 down to Q16
            om_in    = val_type'({1'b0, rnd29[VAL_W-2:0]});
            dv_in    = '0;
            state_in = ST_W_U;
         end
         ST_LENS_RA2: if (mul_done) begin
            tmp_in   = raw_v;
            state_in = ST_LENS_RB2;
         end
         ST_LENS_RB2: if (mul_done) begin
            acc_in   = tmp_ff - raw_v;
            state_in = ST_LENS_T;
         end
         ST_LENS_T: if (div_done) begin
            tp_in    = q_v + h_v;
            tm_in    = q_v - h_v;
            state_in = ST_LENS_S1;
         end
         ST_LENS_S1: if (mul_done) begin
            tmp_in   = v24;
            state_in = ST_LENS_X1;
         end
         ST_LENS_X1: if (mul_done) begin
            acc_in   = v24;
            state_in = ST_LENS_S2;
         end
         ST_LENS_S2: if (mul_done) begin
            tmp_in   = v24;
            state_in = ST_LENS_X2;
         end
         ST_LENS_X2: if (mul_done) begin
            om_in = apply_sign(x_sum < 0, om_mag);
            // touching spheres: no derivative
            if (r_v == sum_v) begin
               dv_in    = '0;
               state_in = ST_W_U;
            end else begin
               state_in = ST_LENS_S3;
            end
         end
         ST_LENS_S3: if (mul_done) begin
            tmp_in   = v24;
            state_in = ST_LENS_Y1;
         end
         ST_LENS_Y1: if (mul_done) begin
            acc_in   = v24;
            state_in = ST_LENS_S4;
         end
         ST_LENS_S4: if (mul_done) begin
            tmp_in   = v24;
            state_in = ST_LENS_Y2;
         end
         ST_LENS_Y2: if (mul_done) begin
            acc_in   = y_sum;
            state_in = ST_LENS_DV;
         end
         ST_LENS_DV: if (div_done) begin
            dv_in    = q_big ? (div_neg_ff ? -LIM : LIM) : q_v;
            sat_in   = sat_ff | q_big;
            state_in = ST_W_U;
         end
         ST_W_U: if (mul_done) begin
            u_in     = smul_v;
            sat_in   = sat_ff | sat16;
            state_in = ST_W_F;
         end
         ST_W_F: if (mul_done) begin
            f_in   = smul_v;
            sat_in = sat_ff | sat16;
            if (core_ff && r_v <= ONE_Q16) begin
               p_in     = val_type'(64'sd1 <<< 30);
               cnt_in   = '0;
               state_in = ST_CORE_POW;
            end else begin
               state_in = ST_FR;
            end
         end
         ST_CORE_POW: begin
            if (!issued_ff && cnt_ff == exp_ff) begin
               // power vanished in Q30: reciprocal pinned at the limit
               if (p_ff == '0) begin
                  rm_in    = LIM;
                  sat_in   = 1'b1;
                  state_in = ST_CORE_EE;
               end else begin
                  state_in = ST_CORE_RM;
               end
            end else if (mul_done) begin
               p_in   = val_type'({1'b0, rnd30[VAL_W-2:0]});
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CORE_RM: if (div_done) begin
            rm_in    = q_big ? LIM : q_v;
            sat_in   = sat_ff | q_big;
            state_in = ST_CORE_EE;
         end
         ST_CORE_EE: if (mul_done) begin
            tmp_in   = smul_v;
            sat_in   = sat_ff | sat16;
            state_in = ST_CORE_U;
         end
         ST_CORE_U: if (mul_done) begin
            u_in     = clampw(uc_v);
            sat_in   = sat_ff | sat16 | over_lim(uc_v);
            state_in = ST_CORE_CE;
         end
         ST_CORE_CE: if (mul_done) begin
            tmp_in   = smul_v;
            sat_in   = sat_ff | sat16;
            state_in = ST_CORE_CER;
         end
         ST_CORE_CER: if (mul_done) begin
            tmp_in   = smul_v;
            sat_in   = sat_ff | sat16;
            state_in = ST_CORE_SC;
         end
         ST_CORE_SC: if (mul_done) begin
            f_in     = clampw(fs_v);
            sat_in   = sat_ff | raw_big | over_lim(fs_v);
            state_in = ST_FR;
         end
         ST_FR: if (mul_done) begin
            if (pot_pre < -(val_type'(64'sd1 <<< 31))) begin
               pot_in = {1'b1, {(OUT_W-1){1'b0}}};
               sat_in = 1'b1;
            end else begin
               pot_in = pot_pre[OUT_W-1:0];
            end
            // force clipped when f*r falls below minus the cutoff
            if (fr_v < -(cut_v <<< 16)) begin
               frc_in = -(cut_v[OUT_W-1:0]);
            end else if (nf_v > val_type'(64'sd2147483647)) begin
               frc_in = {1'b0, {(OUT_W-1){1'b1}}};
               sat_in = 1'b1;
            end else if (nf_v < -(val_type'(64'sd1 <<< 31))) begin
               frc_in = {1'b1, {(OUT_W-1){1'b0}}};
               sat_in = 1'b1;
            end else begin
               frc_in = nf_v[OUT_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_if.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ra_ff      <= ra_in;
      rb_ff      <= rb_in;
      r_ff       <= r_in;
      w_ff       <= w_in;
      core_ff    <= core_in;
      tp_ff      <= tp_in;
      tm_ff      <= tm_in;
      tmp_ff     <= tmp_in;
      acc_ff     <= acc_in;
      om_ff      <= om_in;
      dv_ff      <= dv_in;
      u_ff       <= u_in;
      f_ff       <= f_in;
      p_ff       <= p_in;
      rm_ff      <= rm_in;
      cnt_ff     <= cnt_in;
      sat_ff     <= sat_in;
      mul_neg_ff <= mul_neg_in;
      div_neg_ff <= div_neg_in;
      pot_ff     <= pot_in;
      frc_ff     <= frc_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
         cutoff_ff <= {CFG_W{1'b1}};
         coef_ff   <= '0;
         exp_ff    <= EXP_W'(1);
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         cutoff_ff <= cutoff_in;
         coef_ff   <= coef_in;
         exp_ff    <= exp_in;
      end
   end

   opp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (opa_mag[MAG_W-1:0]),
      .op_b  (opb_mag[MAG_W-1:0]),
      .done  (mul_done),
      .prod  (prod)
   );

   opp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_mag[NUM_W-1:0]),
      .den   (div_den_v[DEN_W-1:0]),
      .done  (div_done),
      .quo   (quo)
   );

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign csr_if.ready     = 1'b1;
   assign rsp_if.valid     = (state_ff == ST_DONE);
   assign rsp_if.potential = pot_ff;
   assign rsp_if.force_res = frc_ff;
   assign rsp_if.saturated = sat_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("result pending while input is open");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_CLASSIFY)
      else $error("accepted beat did not start the sequence");

   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      (mul_done || div_done) |-> issued_ff)
      else $error("unit finished without an issued operation");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !div_start && !issued_ff)
      else $error("shared units started together");

endmodule
`default_nettype wire
